/* sv/ncac_pkg.sv */
// Shared types, widths and codes for the nearest centroid anomaly classifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package ncac_pkg;

  localparam int unsigned DIMS          = 5;
  localparam int unsigned COORD_W       = 16;
  localparam int unsigned MAG_W         = 16;
  localparam int unsigned SQ_W          = 2 * MAG_W;
  localparam int unsigned DIST_W        = 35;
  localparam int unsigned LIMIT_W       = 16;
  localparam int unsigned REGIME_W      = 2;
  localparam int unsigned CFG_W         = 8;
  localparam int unsigned IN_IDX_W      = 7;
  localparam int unsigned OUT_IDX_W     = 7;
  localparam int unsigned DEC_W         = 2;
  localparam int unsigned S_TDATA_W     = 112;
  localparam int unsigned M_TDATA_W     = 48;

  localparam int unsigned DEF_MAX_CENTROIDS = 128;
  localparam logic [CFG_W-1:0] CFG_COUNT_RST = 8'd100;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [REGIME_W-1:0] REGIME_PROVIDE = 2'd0;
  localparam logic [REGIME_W-1:0] REGIME_TAKE    = 2'd1;

  typedef enum logic [DEC_W-1:0] {
    DEC_CANCEL  = 2'd0,
    DEC_TAKER   = 2'd1,
    DEC_PROVIDE = 2'd2,
    DEC_HOLD    = 2'd3
  } decision_e;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [DIMS-1:0] point_t;

  typedef struct packed {
    logic [REGIME_W-1:0] regime;
    logic [LIMIT_W-1:0]  limit;
    point_t              coords;
  } entry_t;

endpackage

`default_nettype wire

/* sv/ncac_dist.sv */
// Squared Euclidean distance pipeline: abs difference, square, two adder levels.
// Four register stages, one pair per cycle, sideband tag carried along; uses ncac_pkg.
`default_nettype none

module ncac_dist #(
  parameter int unsigned TAG_W = 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic [TAG_W-1:0]           in_tag_i,
  input  wire ncac_pkg::point_t           centroid_i,
  input  wire ncac_pkg::point_t           point_i,
  output logic                            out_valid_o,
  output logic [TAG_W-1:0]                out_tag_o,
  output logic [ncac_pkg::DIST_W-1:0]     out_dist_o
);
  import ncac_pkg::*;

  logic                      v1_q, v2_q, v3_q, v4_q;
  logic [TAG_W-1:0]          tag1_q, tag2_q, tag3_q, tag4_q;
  logic [DIMS-1:0][MAG_W-1:0] mag_d, mag_q;
  logic [DIMS-1:0][SQ_W-1:0]  sq_q;
  logic [SQ_W:0]             s01_q, s23_q;
  logic [SQ_W-1:0]           s4_q;
  logic [DIST_W-1:0]         sum_q;

  always_comb begin
    logic signed [COORD_W:0] diff;
    for (int d = 0; d < DIMS; d++) begin
      diff = $signed({centroid_i[d][COORD_W-1], centroid_i[d]})
           - $signed({point_i[d][COORD_W-1], point_i[d]});
      mag_d[d] = diff[COORD_W] ? MAG_W'(-diff) : MAG_W'(diff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tag1_q <= in_tag_i;
    mag_q  <= mag_d;
    tag2_q <= tag1_q;
    for (int d = 0; d < DIMS; d++) begin
      sq_q[d] <= SQ_W'(mag_q[d]) * SQ_W'(mag_q[d]);
    end
    tag3_q <= tag2_q;
    s01_q  <= (SQ_W+1)'(sq_q[0]) + (SQ_W+1)'(sq_q[1]);
    s23_q  <= (SQ_W+1)'(sq_q[2]) + (SQ_W+1)'(sq_q[3]);
    s4_q   <= sq_q[4];
    tag4_q <= tag3_q;
    sum_q  <= DIST_W'(s01_q) + DIST_W'(s23_q) + DIST_W'(s4_q);
  end

  assign out_valid_o = v4_q;
  assign out_tag_o   = tag4_q;
  assign out_dist_o  = sum_q;

endmodule

`default_nettype wire

/* sv/nearest_centroid_anomaly_classifier_top.sv */
// Top level: centroid table memory, query sequencer, running minimum and result register.
// Depends on ncac_pkg and ncac_dist.
`default_nettype none

// A load transfer writes one table entry; the block is ready
// again at once. A query walks table entries 0 to N-1 (N is centroid_count, zero read
// as one, capped at MAX_CENTROIDS) through the single read port of the table, one
// entry per cycle, into a six-stage distance and minimum pipeline; input stays blocked
// until the result enters the output register, which waits for a stalled result to
// be taken. Loads may be sent while a result waits on the output. The user must write
// centroid_count only while no query is in flight; the block does not enforce this.
module nearest_centroid_anomaly_classifier_top #(
  parameter int unsigned MAX_CENTROIDS = ncac_pkg::DEF_MAX_CENTROIDS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ncac_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // entry_index[6:0], coord_0..coord_4[86:7], limit_in[102:87], regime_in[104:103]
  input  wire logic [ncac_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // func
  input  wire logic                          s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // best_index[6:0], min_dist_sq[41:7], anomaly[42], decision[44:43]
  output logic [ncac_pkg::M_TDATA_W-1:0]     m_axis_tdata_o
);
  import ncac_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_CENTROIDS);
  localparam int unsigned CW    = $clog2(MAX_CENTROIDS + 1);
  localparam int unsigned LW    = (CW > CFG_W) ? CW : CFG_W;
  localparam int unsigned TAG_W = 2 + IDX_W + LIMIT_W + REGIME_W;

  // input unpack
  logic [IN_IDX_W-1:0] in_idx;
  entry_t              in_entry;
  logic                in_xfer, load_xfer, query_xfer;

  assign in_idx          = s_axis_tdata_i[IN_IDX_W-1:0];
  assign in_entry.coords = s_axis_tdata_i[IN_IDX_W +: DIMS*COORD_W];
  assign in_entry.limit  = s_axis_tdata_i[IN_IDX_W + DIMS*COORD_W +: LIMIT_W];
  assign in_entry.regime = s_axis_tdata_i[IN_IDX_W + DIMS*COORD_W + LIMIT_W +: REGIME_W];

  logic busy_q;
  assign s_axis_tready_o = !busy_q;
  assign in_xfer    = s_axis_tvalid_i && !busy_q;
  assign load_xfer  = in_xfer && (s_axis_tuser_i == FUNC_LOAD);
  assign query_xfer = in_xfer && (s_axis_tuser_i == FUNC_QUERY);

  // config register
  logic [CFG_W-1:0] count_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CFG_COUNT_RST;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  logic [LW-1:0]    eff_count;
  logic [IDX_W-1:0] last_d;
  always_comb begin
    priority if (count_q == '0) begin
      eff_count = LW'(1);
    end else if (LW'(count_q) > LW'(MAX_CENTROIDS)) begin
      eff_count = LW'(MAX_CENTROIDS);
    end else begin
      eff_count = LW'(count_q);
    end
    last_d = IDX_W'(eff_count - LW'(1));
  end

  // centroid table
  entry_t mem_q [MAX_CENTROIDS];
  entry_t rd_q;
  logic [IDX_W-1:0] cnt_q, last_q;

  always_ff @(posedge clk_i) begin
    if (load_xfer && (LW'(in_idx) < LW'(MAX_CENTROIDS))) begin
      mem_q[IDX_W'(in_idx)] <= in_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[cnt_q];
  end

  // sequencer: issue one entry per cycle
  point_t           qpt_q;
  logic             issue_q;
  logic             v0_q, first0_q, last0_q;
  logic [IDX_W-1:0] idx0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      cnt_q   <= '0;
      v0_q    <= 1'b0;
    end else begin
      v0_q <= issue_q;
      if (query_xfer) begin
        issue_q <= 1'b1;
        cnt_q   <= '0;
      end else if (issue_q) begin
        cnt_q <= IDX_W'(cnt_q + IDX_W'(1));
        if (cnt_q == last_q) begin
          issue_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_xfer) begin
      qpt_q  <= in_entry.coords;
      last_q <= last_d;
    end
    idx0_q   <= cnt_q;
    first0_q <= (cnt_q == '0);
    last0_q  <= (cnt_q == last_q);
  end

  // distance pipeline
  logic [TAG_W-1:0]  tag_in, tag_out;
  logic              dv;
  logic [DIST_W-1:0] dist_sum;

  assign tag_in = {first0_q, last0_q, idx0_q, rd_q.limit, rd_q.regime};

  ncac_dist #(
    .TAG_W (TAG_W)
  ) u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v0_q),
    .in_tag_i    (tag_in),
    .centroid_i  (rd_q.coords),
    .point_i     (qpt_q),
    .out_valid_o (dv),
    .out_tag_o   (tag_out),
    .out_dist_o  (dist_sum)
  );

  logic                d_first, d_last;
  logic [IDX_W-1:0]    d_idx;
  logic [LIMIT_W-1:0]  d_limit;
  logic [REGIME_W-1:0] d_regime;
  assign {d_first, d_last, d_idx, d_limit, d_regime} = tag_out;

  // running minimum; strict compare keeps the lowest index on ties
  logic [DIST_W-1:0]   best_d_q;
  logic [IDX_W-1:0]    best_idx_q;
  logic [LIMIT_W-1:0]  best_lim_q;
  logic [REGIME_W-1:0] best_reg_q;
  logic [SQ_W-1:0]     lsq_q;
  logic                done1_q, done2_q;

  always_ff @(posedge clk_i) begin
    if (dv && (d_first || (dist_sum < best_d_q))) begin
      best_d_q   <= dist_sum;
      best_idx_q <= d_idx;
      best_lim_q <= d_limit;
      best_reg_q <= d_regime;
    end
    if (done1_q) begin
      lsq_q <= SQ_W'(best_lim_q) * SQ_W'(best_lim_q);
    end
  end

  // result
  logic      out_free, anomaly;
  decision_e decision;
  logic      out_valid_q;
  logic [M_TDATA_W-1:0] out_data_q;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign anomaly  = best_d_q > DIST_W'(lsq_q);

  always_comb begin
    priority if (anomaly) begin
      decision = DEC_CANCEL;
    end else if (best_reg_q == REGIME_TAKE) begin
      decision = DEC_TAKER;
    end else if (best_reg_q == REGIME_PROVIDE) begin
      decision = DEC_PROVIDE;
    end else begin
      decision = DEC_HOLD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      done1_q     <= 1'b0;
      done2_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (query_xfer) begin
        busy_q <= 1'b1;
      end
      done1_q <= dv && d_last;
      if (done1_q) begin
        done2_q <= 1'b1;
      end
      if (done2_q && out_free) begin
        done2_q     <= 1'b0;
        busy_q      <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done2_q && out_free) begin
      out_data_q <= M_TDATA_W'({decision, anomaly, best_d_q, OUT_IDX_W'(best_idx_q)});
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire

/* sv/ncac_checker.sv */
// Port-level checks for the nearest centroid anomaly classifier top, plus its bind.
// Depends on ncac_pkg and nearest_centroid_anomaly_classifier_top.
`default_nettype none

module ncac_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid_i,
  input wire logic                           s_axis_tready_o,
  input wire logic                           s_axis_tuser_i,
  input wire logic                           m_axis_tvalid_o,
  input wire logic                           m_axis_tready_i,
  input wire logic [ncac_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);
  import ncac_pkg::*;

  logic s_xfer;
  assign s_xfer = s_axis_tvalid_i && s_axis_tready_o;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // a query blocks the input for its walk
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && (s_axis_tuser_i == FUNC_QUERY) |=> !s_axis_tready_o)
    else $error("input ready right after a query transfer");

  // loads never block the input
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && (s_axis_tuser_i == FUNC_LOAD) |=> s_axis_tready_o)
    else $error("input blocked after a load transfer");

  // anomaly and cancel-all go together
  a_cancel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[42] == (m_axis_tdata_o[44:43] == DEC_CANCEL)))
    else $error("anomaly flag and decision disagree");

  // no result can appear right after a query starts
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && (s_axis_tuser_i == FUNC_QUERY) |=> !$rose(m_axis_tvalid_o))
    else $error("result too early after query");

endmodule

bind nearest_centroid_anomaly_classifier_top ncac_checker u_ncac_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire

/* bench/ncac_classify_monitor.sv */
`timescale 1ns / 100ps
// Passive monitor for the nearest centroid classifier: mirrors the centroid table and the
// search count, predicts one verdict per query transfer and compares each result transfer.
// Depends on ncac_pkg.
module ncac_classify_monitor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ncac_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  // entry_index[6:0], coord_0..coord_4[86:7], limit_in[102:87], regime_in[104:103]
  input  logic [ncac_pkg::S_TDATA_W-1:0] s_tdata_i,
  // func
  input  logic                           s_tuser_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  // best_index[6:0], min_dist_sq[41:7], anomaly[42], decision[44:43]
  input  logic [ncac_pkg::M_TDATA_W-1:0] m_tdata_i,
  output int                             fail_count_o,
  output int                             outstanding_o
);
  import ncac_pkg::*;

  localparam int unsigned DEPTH = DEF_MAX_CENTROIDS;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] index;
    logic [DIST_W-1:0]    dist_sq;
    logic                 anomaly;
    decision_e            decision;
  } verdict_t;

  point_t              centroid_tab [DEPTH];
  logic [LIMIT_W-1:0]  limit_tab [DEPTH];
  logic [REGIME_W-1:0] regime_tab [DEPTH];
  logic [CFG_W-1:0]    search_count;
  verdict_t            pending_verdicts [$];
  int                  fail_count = 0;

  assign fail_count_o = fail_count;

  function automatic longint unsigned sq_distance(point_t a, point_t b);
    longint unsigned sum;
    longint          diff;
    sum = 0;
    for (int d = 0; d < DIMS; d++) begin
      diff = longint'(a[d]) - longint'(b[d]);
      sum += diff * diff;
    end
    return sum;
  endfunction

  function automatic verdict_t classify_point(point_t pt);
    verdict_t          v;
    int unsigned       n;
    int unsigned       best;
    longint unsigned   best_d;
    longint unsigned   d_k;
    longint unsigned   lim;
    // zero reads as one, anything past the table saturates
    n = (search_count == 0) ? 1 : search_count;
    if (n > DEPTH) n = DEPTH;
    best = 0;
    best_d = sq_distance(centroid_tab[0], pt);
    for (int unsigned k = 1; k < n; k++) begin
      d_k = sq_distance(centroid_tab[k], pt);
      // strict compare keeps the lowest index on ties
      if (d_k < best_d) begin
        best_d = d_k;
        best = k;
      end
    end
    lim = limit_tab[best];
    v.index   = OUT_IDX_W'(best);
    v.dist_sq = DIST_W'(best_d);
    v.anomaly = best_d > lim * lim;
    if (v.anomaly) v.decision = DEC_CANCEL;
    else if (regime_tab[best] == REGIME_TAKE) v.decision = DEC_TAKER;
    else if (regime_tab[best] == REGIME_PROVIDE) v.decision = DEC_PROVIDE;
    else v.decision = DEC_HOLD;
    return v;
  endfunction

  task automatic report_failure(string msg);
    if (fail_count < 40) $display("%0t: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    entry_t              item;
    logic [IN_IDX_W-1:0] idx;
    verdict_t            seen;
    verdict_t            want;
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) begin
        centroid_tab[k] = '0;
        limit_tab[k]    = '0;
        regime_tab[k]   = '0;
      end
      search_count = CFG_COUNT_RST;
      pending_verdicts.delete();
      outstanding_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        seen.index    = m_tdata_i[6:0];
        seen.dist_sq  = m_tdata_i[41:7];
        seen.anomaly  = m_tdata_i[42];
        seen.decision = decision_e'(m_tdata_i[44:43]);
        if (pending_verdicts.size() == 0) begin
          report_failure($sformatf("result transfer with no query pending, index %0d",
                                   seen.index));
        end else begin
          want = pending_verdicts.pop_front();
          if (seen.index !== want.index)
            report_failure($sformatf("best_index got %0d, expected %0d",
                                     seen.index, want.index));
          if (seen.dist_sq !== want.dist_sq)
            report_failure($sformatf("min_dist_sq got %0d, expected %0d",
                                     seen.dist_sq, want.dist_sq));
          if (seen.anomaly !== want.anomaly)
            report_failure($sformatf("anomaly got %0d, expected %0d",
                                     seen.anomaly, want.anomaly));
          if (seen.decision !== want.decision)
            report_failure($sformatf("decision got %0d, expected %0d",
                                     seen.decision, want.decision));
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        item = s_tdata_i[IN_IDX_W +: $bits(entry_t)];
        idx  = s_tdata_i[IN_IDX_W-1:0];
        if (s_tuser_i == FUNC_LOAD) begin
          if (idx < DEPTH) begin
            centroid_tab[idx] = item.coords;
            limit_tab[idx]    = item.limit;
            regime_tab[idx]   = item.regime;
          end
        end else begin
          pending_verdicts.insert(pending_verdicts.size(), classify_point(item.coords));
        end
      end
      if (cfg_we_i) search_count = cfg_wdata_i;
      outstanding_o <= pending_verdicts.size();
    end
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Stimulus and verdict for the nearest centroid classifier: fills the table, then runs
// directed and random load/query traffic under several search counts and idle patterns.
// Depends on ncac_pkg, ncac_classify_monitor and the classifier RTL.
module tb_top;
  import ncac_pkg::*;

  localparam int unsigned DEPTH     = DEF_MAX_CENTROIDS;
  localparam int unsigned QUIET     = 12;
  localparam int unsigned DRAIN     = DEPTH + 40;
  localparam int unsigned SEG_ITEMS = 35;

  localparam logic [REGIME_W-1:0] REGIME_HOLD_LO = 2'd2;
  localparam logic [REGIME_W-1:0] REGIME_HOLD_HI = 2'd3;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata   = '0;
  logic                 s_tuser   = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  int                   fail_count;
  int                   outstanding;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  point_t               shadow_pts [DEPTH];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  nearest_centroid_anomaly_classifier_top #(
    .MAX_CENTROIDS(DEPTH)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  ncac_classify_monitor i_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  // result side back-pressure
  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // guard: far above the slowest legal run (every query at full table size, long stalls)
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic point_t uniform_point(coord_t v);
    point_t p;
    for (int d = 0; d < DIMS; d++) p[d] = v;
    return p;
  endfunction

  function automatic point_t random_point();
    point_t p;
    for (int d = 0; d < DIMS; d++) p[d] = coord_t'($urandom);
    return p;
  endfunction

  function automatic coord_t nudge(coord_t c, int span);
    int v;
    v = int'(c) + int'($urandom_range(2 * span)) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return coord_t'(v);
  endfunction

  // thresholds spread over many magnitudes so both verdicts occur
  function automatic logic [LIMIT_W-1:0] draw_limit();
    return LIMIT_W'($urandom_range(65535) >> $urandom_range(15));
  endfunction

  function automatic int eff_count(int v);
    if (v == 0) return 1;
    if (v > DEPTH) return DEPTH;
    return v;
  endfunction

  task automatic push_item(logic func, logic [IN_IDX_W-1:0] idx, entry_t item);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {{(S_TDATA_W - IN_IDX_W - $bits(entry_t)){1'b0}}, item, idx};
    do begin
      @(posedge clk_i);
    end while (!s_tready);
  endtask

  task automatic load_entry(int idx, point_t pt, logic [LIMIT_W-1:0] lim,
                            logic [REGIME_W-1:0] code);
    entry_t e;
    e.coords = pt;
    e.limit  = lim;
    e.regime = code;
    shadow_pts[idx] = pt;
    push_item(FUNC_LOAD, IN_IDX_W'(idx), e);
  endtask

  // limit, regime and index ride along with random content; the block ignores them
  task automatic query_point(point_t pt);
    entry_t e;
    e.coords = pt;
    e.limit  = LIMIT_W'($urandom);
    e.regime = REGIME_W'($urandom);
    push_item(FUNC_QUERY, IN_IDX_W'($urandom), e);
  endtask

  task automatic wait_idle(int extra);
    s_tvalid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (outstanding != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_count(int v);
    wait_idle(QUIET);
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(v);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_segment(int n_items, int active);
    int     pick;
    int     span;
    int     k;
    int     idx;
    point_t pt;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      k    = $urandom_range(active - 1);
      case ($urandom_range(3))
        0:       span = 0;
        1:       span = 24;
        2:       span = 400;
        default: span = 6000;
      endcase
      for (int d = 0; d < DIMS; d++) pt[d] = nudge(shadow_pts[k][d], span);
      if (pick < 30) begin
        idx = $urandom_range(1) ? $urandom_range(active - 1) : $urandom_range(DEPTH - 1);
        case ($urandom_range(3))
          0:       pt = random_point();
          1:       pt = shadow_pts[k];  // exact copy sets up a tie
          default: ;
        endcase
        load_entry(idx, pt, draw_limit(), REGIME_W'($urandom_range(3)));
      end else if (pick < 88) begin
        query_point(pt);
      end else begin
        query_point(random_point());
      end
    end
  endtask

  initial begin
    point_t p;
    int     setting;
    send_idle_pct = 6;
    recv_idle_pct = 50;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every entry written once, so no search ever reaches an empty slot
    for (int k = 0; k < DEPTH; k++)
      load_entry(k, random_point(), draw_limit(), REGIME_W'($urandom_range(3)));

    // corners of the coordinate range, searched with the reset count
    load_entry(0, uniform_point(coord_t'(16'h8000)), 16'hFFFF, REGIME_PROVIDE);
    load_entry(1, uniform_point(coord_t'(16'h7FFF)), 16'h0000, REGIME_TAKE);
    p = uniform_point(coord_t'(16'h1234));
    p[2] = coord_t'(-100);
    load_entry(2, p, draw_limit(), REGIME_HOLD_LO);
    load_entry(3, p, draw_limit(), REGIME_HOLD_HI);
    query_point(uniform_point(coord_t'(16'h7FFF)));
    query_point(uniform_point(coord_t'(16'h8000)));
    query_point(p);
    // distance equal to the threshold squared, then one step beyond
    p = uniform_point(coord_t'(-2000));
    load_entry(4, p, 16'd300, REGIME_HOLD_HI);
    p[3] = coord_t'(int'(p[3]) + 300);
    query_point(p);
    p[3] = coord_t'(int'(p[3]) + 1);
    query_point(p);
    // zero count: entry 0 alone, farthest point gives the largest distance
    write_count(0);
    query_point(uniform_point(coord_t'(16'h7FFF)));
    query_point(uniform_point(coord_t'(0)));
    // count past the table saturates, so the last entry is searched
    write_count(255);
    p = uniform_point(coord_t'(0));
    p[0] = coord_t'(16'h7FFF);
    p[1] = coord_t'(16'h8000);
    p[3] = coord_t'(1);
    p[4] = coord_t'(-1);
    load_entry(DEPTH - 1, p, 16'h0100, REGIME_TAKE);
    query_point(p);
    query_point(uniform_point(coord_t'(16'h8000)));

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 50;
        end
        1: begin
          send_idle_pct = 50;
          recv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < 10; s++) begin
        case (s)
          0:       setting = 0;
          1:       setting = 1;
          2:       setting = 2;
          3:       setting = 7;
          4:       setting = 33;
          5:       setting = 100;
          6:       setting = 128;
          7:       setting = 129;
          8:       setting = 255;
          default: setting = $urandom_range(1, 255);
        endcase
        write_count(setting);
        run_segment(SEG_ITEMS, eff_count(setting));
      end
    end

    wait_idle(DRAIN);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
